// ----- rtl/kpc_pkg.sv -----
// Package for the key press classifier.
// Holds widths, register indexes, the press event codes and the configuration struct.
// No dependencies.
`default_nettype none

package kpc_pkg;

  localparam int unsigned CntW  = 12;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [CfgW-1:0] MinPressReset    = 11'd20;
  localparam logic [CfgW-1:0] LongPressReset   = 11'd600;
  localparam logic [CfgW-1:0] DoubleWinReset   = 11'd100;

  typedef enum logic [1:0] {
    REG_MIN_PRESS  = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DOUBLE_WIN = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_SHORT  = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_LONG   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CfgW-1:0] min_press_ticks;
    logic [CfgW-1:0] long_press_ticks;
    logic [CfgW-1:0] double_window_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/key_press_classifier.sv -----
// Top level of the key press classifier: input register, classifier core, result register.
// Depends on kpc_pkg, kpc_regs and kpc_core.
// Each input beat is one scan tick and yields exactly one result beat holding the stored
// press mode after that tick (none, short, double or long). A beat passes from the input
// register to the result register while the result side is ready, so one tick per cycle
// is sustained then; the only loop is the registered counter update. The user writes the
// configuration registers via the APB port while the stream is idle; no logic enforces it.
`default_nettype none

module key_press_classifier (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [7:0]                s_axis_tdata,  // [0] key_level, [7:1] zero
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic      [7:0]                m_axis_tdata,  // [1:0] press_event, [7:2] zero
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kpc_pkg::AddrW-1:0] paddr,
  input  wire logic [kpc_pkg::DataW-1:0] pwdata,
  output logic      [kpc_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  kpc_pkg::cfg_t  cfg;
  kpc_pkg::mode_e mode_d;
  logic           in_valid_q, in_level_q;
  logic           out_valid_q;
  kpc_pkg::mode_e out_mode_q;
  logic           out_ready, step;

  kpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (in_level_q),
    .cfg_i    (cfg),
    .mode_d_o (mode_d)
  );

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_mode_q <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kpc_regs.sv -----
// Configuration register file of the key press classifier, on an APB-style port.
// Depends on kpc_pkg.
`default_nettype none

module kpc_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kpc_pkg::AddrW-1:0] paddr,
  input  wire logic [kpc_pkg::DataW-1:0] pwdata,
  output logic      [kpc_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output kpc_pkg::cfg_t                  cfg_o
);

  kpc_pkg::cfg_t     cfg_q, cfg_d;
  kpc_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = kpc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        kpc_pkg::REG_MIN_PRESS:  cfg_d.min_press_ticks     = pwdata[kpc_pkg::CfgW-1:0];
        kpc_pkg::REG_LONG_PRESS: cfg_d.long_press_ticks    = pwdata[kpc_pkg::CfgW-1:0];
        kpc_pkg::REG_DOUBLE_WIN: cfg_d.double_window_ticks = pwdata[kpc_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      kpc_pkg::REG_MIN_PRESS:
        prdata[kpc_pkg::CfgW-1:0] = cfg_q.min_press_ticks;
      kpc_pkg::REG_LONG_PRESS:
        prdata[kpc_pkg::CfgW-1:0] = cfg_q.long_press_ticks;
      kpc_pkg::REG_DOUBLE_WIN:
        prdata[kpc_pkg::CfgW-1:0] = cfg_q.double_window_ticks;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_press_ticks     <= kpc_pkg::MinPressReset;
      cfg_q.long_press_ticks    <= kpc_pkg::LongPressReset;
      cfg_q.double_window_ticks <= kpc_pkg::DoubleWinReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kpc_core.sv -----
// Classifier state and its per-tick update: hold counter, click window and stored mode.
// Depends on kpc_pkg.
`default_nettype none

module kpc_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          level_i,
  input  kpc_pkg::cfg_t      cfg_i,
  output kpc_pkg::mode_e     mode_d_o
);

  logic [kpc_pkg::CntW-1:0] hold_q, hold_d, hold_inc;
  logic [kpc_pkg::CntW-1:0] win_q, win_d, win_inc;
  logic                     latched_q, latched_d;
  logic [1:0]               clicks_q, clicks_d;
  logic                     open_q, open_d;
  kpc_pkg::mode_e           mode_q, mode_d;
  logic [kpc_pkg::CntW-1:0] min_x, long_x, dwin_x;

  assign min_x  = {1'b0, cfg_i.min_press_ticks};
  assign long_x = {1'b0, cfg_i.long_press_ticks};
  assign dwin_x = {1'b0, cfg_i.double_window_ticks};

  assign hold_inc = (!latched_q && hold_q != kpc_pkg::CntMax) ? hold_q + 1'b1 : hold_q;

  always_comb begin
    hold_d    = hold_q;
    latched_d = latched_q;
    clicks_d  = clicks_q;
    open_d    = open_q;
    win_d     = win_q;
    mode_d    = mode_q;
    win_inc   = win_q;

    // Key scan.
    if (!level_i) begin
      if (hold_inc > long_x) begin
        hold_d    = '0;
        latched_d = 1'b1;
        mode_d    = kpc_pkg::MODE_LONG;
      end else begin
        hold_d = hold_inc;
        mode_d = kpc_pkg::MODE_NONE;
      end
    end else if (hold_q > min_x && hold_q < long_x && mode_q != kpc_pkg::MODE_LONG) begin
      hold_d    = '0;
      latched_d = 1'b0;
      clicks_d  = clicks_q + 2'd1;
      open_d    = 1'b1;
    end else begin
      hold_d    = '0;
      latched_d = 1'b0;
      mode_d    = kpc_pkg::MODE_NONE;
    end

    // Double-click window, seen after the scan of the same tick.
    if (open_d) begin
      win_inc = (level_i && win_q != kpc_pkg::CntMax) ? win_q + 1'b1 : win_q;
      win_d   = win_inc;
      if (win_inc > dwin_x) begin
        mode_d   = kpc_pkg::MODE_SHORT;
        clicks_d = '0;
        win_d    = '0;
        open_d   = 1'b0;
      end else if (clicks_d > 2'd1) begin
        mode_d   = kpc_pkg::MODE_DOUBLE;
        clicks_d = '0;
        win_d    = '0;
        open_d   = 1'b0;
      end
    end
  end

  assign mode_d_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= '0;
      latched_q <= 1'b0;
      clicks_q  <= '0;
      open_q    <= 1'b0;
      win_q     <= '0;
      mode_q    <= kpc_pkg::MODE_NONE;
    end else if (step_i) begin
      hold_q    <= hold_d;
      latched_q <= latched_d;
      clicks_q  <= clicks_d;
      open_q    <= open_d;
      win_q     <= win_d;
      mode_q    <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/press_event_checker.sv -----
// Checker for the key press classifier: watches the tick, result and APB channels.
// Predicts the press mode after every accepted tick and compares it with each result beat.
// Depends on kpc_pkg.
module press_event_checker
  import kpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] key_level, [7:1] zero
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [7:0]       m_axis_tdata,   // [1:0] press_event, [7:2] zero
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t            limits;
  logic [CntW-1:0] hold_cnt;
  logic            long_held;
  logic [1:0]      clicks;
  logic            win_open;
  logic [CntW-1:0] win_cnt;
  mode_e           mode;
  mode_e           want_mode;
  mode_e           expected_modes[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count = fail_count + 1;
  endtask

  function automatic mode_e classify_tick(input logic level);
    logic done;
    done = 1'b0;
    if (!level) begin
      if (!long_held && hold_cnt != CntMax) hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt > limits.long_press_ticks) begin
        hold_cnt  = '0;
        mode      = MODE_LONG;
        long_held = 1'b1;
      end else begin
        mode = MODE_NONE;
      end
    end else if (hold_cnt > limits.min_press_ticks && hold_cnt < limits.long_press_ticks &&
                 mode != MODE_LONG) begin
      long_held = 1'b0;
      hold_cnt  = '0;
      clicks    = clicks + 2'd1;
      win_open  = 1'b1;
    end else begin
      long_held = 1'b0;
      hold_cnt  = '0;
      mode      = MODE_NONE;
    end
    if (win_open) begin
      if (level && win_cnt != CntMax) win_cnt = win_cnt + 1'b1;
      if (win_cnt > limits.double_window_ticks) begin
        mode = MODE_SHORT;
        done = 1'b1;
      end else if (clicks > 2'd1) begin
        mode = MODE_DOUBLE;
        done = 1'b1;
      end
      if (done) begin
        clicks   = '0;
        win_cnt  = '0;
        win_open = 1'b0;
      end
    end
    return mode;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits.min_press_ticks     = MinPressReset;
      limits.long_press_ticks    = LongPressReset;
      limits.double_window_ticks = DoubleWinReset;
      hold_cnt   = '0;
      long_held  = 1'b0;
      clicks     = '0;
      win_open   = 1'b0;
      win_cnt    = '0;
      mode       = MODE_NONE;
      fail_count = 0;
      expected_modes.delete();
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_MIN_PRESS:  limits.min_press_ticks     = pwdata[CfgW-1:0];
          REG_LONG_PRESS: limits.long_press_ticks    = pwdata[CfgW-1:0];
          REG_DOUBLE_WIN: limits.double_window_ticks = pwdata[CfgW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_modes.push_back(classify_tick(s_axis_tdata[0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_modes.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%02h with no tick pending", m_axis_tdata));
        end else begin
          want_mode = expected_modes.pop_front();
          if (m_axis_tdata[1:0] != want_mode) begin
            report_mismatch($sformatf("press_event %0d, expected %0d (%s)",
                                      m_axis_tdata[1:0], want_mode, want_mode.name()));
          end
          if (m_axis_tdata[7:2] != '0) begin
            report_mismatch($sformatf("padding bits of result beat are 0x%02h",
                                      m_axis_tdata[7:2]));
          end
        end
      end
      pending_count <= expected_modes.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the key press classifier: clock, reset, tick and result streams, APB writes.
// Runs directed and random press sequences under several threshold settings and gives the verdict.
// Depends on kpc_pkg, key_press_classifier and press_event_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kpc_pkg::*;

  localparam int CycleLimit    = 400_000;
  localparam int SettleCycles  = 6;
  localparam int HoldOffCycles = 80;
  localparam int DirRuns[13]   = '{1, 1, 1, 2, 1, 2, 1, 3, 3, 6, 1, 4, 1};

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [DataW-1:0] pwdata        = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int   fail_count;
  int   pending_count;
  int   cycle_count   = 0;
  bit   quiet         = 1'b0;
  bit   long_hold_req = 1'b0;
  int   cur_min       = 20;
  int   cur_long      = 600;
  int   cur_win       = 100;

  always #2 clk_i = ~clk_i;

  key_press_classifier dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  press_event_checker press_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .fail_count,
    .pending_count
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The long hold-off lets the block fill up and push back on the tick stream.
  initial begin : receiver
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  task automatic send_tick(input logic level);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input int unsigned value);
    logic [DataW-1:0] word;
    word = $urandom;
    word[CfgW-1:0] = value[CfgW-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input int min_ticks, input int long_ticks, input int win_ticks);
    apb_write(REG_MIN_PRESS, min_ticks);
    apb_write(REG_LONG_PRESS, long_ticks);
    apb_write(REG_DOUBLE_WIN, win_ticks);
    cur_min  = min_ticks;
    cur_long = long_ticks;
    cur_win  = win_ticks;
  endtask

  // Run lengths cluster around the thresholds so that every outcome is reached.
  function automatic int pick_run(input logic held);
    int picks[8];
    int run;
    if (held) begin
      picks = '{1, cur_min, cur_min + 1, cur_min + 2, cur_long - 1, cur_long, cur_long + 1,
                $urandom_range(1, 16)};
    end else begin
      picks = '{1, 1, cur_win - 1, cur_win, cur_win + 1, cur_win + 2, 2, $urandom_range(1, 8)};
    end
    run = picks[$urandom_range(0, 7)];
    if (run > 64) run = $urandom_range(1, 64);
    if (run < 1) run = 1;
    return run;
  endfunction

  task automatic play_presses(input int budget);
    int   sent;
    int   run;
    logic level;
    sent  = 0;
    level = 1'b0;
    while (sent < budget) begin
      run = pick_run(level == 1'b0);
      repeat (run) send_tick(level);
      sent  = sent + run;
      level = ~level;
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();
  endtask

  initial begin : stimulus
    logic level;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_write(REG_NONE, $urandom);
    set_limits(1, 4, 2);
    level = 1'b1;
    foreach (DirRuns[i]) begin
      repeat (DirRuns[i]) send_tick(level);
      level = ~level;
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    set_limits(3, 12, 6);
    play_presses(200);
    set_limits(0, 1, 1);
    play_presses(60);
    set_limits(0, 2047, 2047);
    play_presses(40);
    set_limits(2047, 2047, 1);
    play_presses(40);
    set_limits(20, 600, 100);
    play_presses(150);
    set_limits(5, 9, 4);
    long_hold_req = 1'b1;
    play_presses(200);
    quiet = 1'b1;
    set_limits(3, 12, 6);
    play_presses(150);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
